@@ rtl/rmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared widths, codes, reset values and types of the streamline ROI mask
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmf_pkg;

    // default per-axis voxel index width
    localparam int AXIS_BITS_DEF = 7;

    // payload field widths
    localparam int ACTION_W   = 1;
    localparam int MADDR_W    = 21;
    localparam int COORD_W    = 24;
    localparam int COUNT_W    = 32;

    // configuration register widths
    localparam int INV_W      = 24;
    localparam int DIMCFG_W   = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // fraction bits: Q15.8 coordinate times Q8.16 reciprocal
    localparam int COORD_FRAC_W = 8;
    localparam int INV_FRAC_W   = 16;
    localparam int PROD_FRAC_W  = COORD_FRAC_W + INV_FRAC_W;

    // register reset values
    localparam logic [INV_W-1:0]    INV_RESET = 24'd65536;
    localparam logic [DIMCFG_W-1:0] DIM_RESET = 8'd128;

    // transaction kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_MASK_WRITE = 1'b0,
        ACT_POINT      = 1'b1
    } action_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_X = 3'd0,
        REG_INV_Y = 3'd1,
        REG_INV_Z = 3'd2,
        REG_DIM_X = 3'd3,
        REG_DIM_Y = 3'd4,
        REG_DIM_Z = 3'd5
    } cfg_reg_t;

    // configuration set handed to the voxel mapper
    typedef struct packed {
        logic [INV_W-1:0]    inv_x;
        logic [INV_W-1:0]    inv_y;
        logic [INV_W-1:0]    inv_z;
        logic [DIMCFG_W-1:0] dim_x;
        logic [DIMCFG_W-1:0] dim_y;
        logic [DIMCFG_W-1:0] dim_z;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/rmf_if.sv @@
// ----------------------------------------------------------------------------
// rmf_if
// Valid/ready channels of the ROI mask filter: the point and mask-write
// stream, and the per-track result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmf_stream_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [rmf_pkg::MADDR_W-1:0]       mask_address;
    logic                              mask_nonzero;
    logic signed [rmf_pkg::COORD_W-1:0] coord_x;
    logic signed [rmf_pkg::COORD_W-1:0] coord_y;
    logic signed [rmf_pkg::COORD_W-1:0] coord_z;
    logic                              last_point;

    modport source (
        output valid, action, mask_address, mask_nonzero,
        output coord_x, coord_y, coord_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, action, mask_address, mask_nonzero,
        input  coord_x, coord_y, coord_z, last_point,
        output ready
    );
endinterface

interface rmf_result_if;
    logic                          valid;
    logic                          ready;
    logic                          keep_track;
    logic [rmf_pkg::COUNT_W-1:0]   kept_total;

    modport source (
        output valid, keep_track, kept_total,
        input  ready
    );
    modport sink (
        input  valid, keep_track, kept_total,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/rmf_mask_ram.sv @@
// ----------------------------------------------------------------------------
// rmf_mask_ram
// One-bit mask volume: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_mask_ram #(
    parameter int ADDR_W = 3 * rmf_pkg::AXIS_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic              wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic                   rdata
);

    logic mem [0:(1 << ADDR_W)-1];
    logic rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data valid in the cycle after re
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/rmf_voxel_map.sv @@
// ----------------------------------------------------------------------------
// rmf_voxel_map
// Four-stage point to voxel index pipeline: scale, floor and clamp, index
// products, index sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rmf_voxel_map #(
    parameter int AXIS_BITS = rmf_pkg::AXIS_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [rmf_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [rmf_pkg::COORD_W-1:0]  coord_y,
    input  wire logic signed [rmf_pkg::COORD_W-1:0]  coord_z,
    input  wire rmf_pkg::cfg_t                       cfg,
    output logic                                     map_valid,
    output logic [3*AXIS_BITS-1:0]                   map_addr
);

    localparam int ADDR_W  = 3 * AXIS_BITS;
    localparam int DIM_W   = AXIS_BITS + 1;
    localparam int PROD_W  = rmf_pkg::COORD_W + rmf_pkg::INV_W + 1;
    localparam int WHOLE_W = PROD_W - rmf_pkg::PROD_FRAC_W;
    localparam int DXY_W   = 2 * DIM_W;
    localparam int T1_W    = AXIS_BITS + DIM_W;
    localparam int T2_W    = AXIS_BITS + DXY_W;
    localparam int SUM_W   = T2_W + 1;
    localparam int STAGES  = 4;

    // dimension zero counts as one, larger than the axis range saturates
    function automatic logic [DIM_W-1:0] eff_dim(input logic [rmf_pkg::DIMCFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (32'(d) > (32'd1 << AXIS_BITS))
            r = DIM_W'(32'd1 << AXIS_BITS);
        else
            r = DIM_W'(d);
        return r;
    endfunction

    // floor of the scaled coordinate, clamped to 0..d-1
    function automatic logic [AXIS_BITS-1:0] clamp_axis(
        input logic signed [PROD_W-1:0] p,
        input logic [DIM_W-1:0]         d
    );
        logic [WHOLE_W-1:0]   whole;
        logic [DIM_W-1:0]     top;
        logic [AXIS_BITS-1:0] r;
        whole = p[PROD_W-1:rmf_pkg::PROD_FRAC_W];
        top   = d - DIM_W'(1);
        if (p[PROD_W-1])
            r = '0;
        else if (whole >= WHOLE_W'(d))
            r = top[AXIS_BITS-1:0];
        else
            r = whole[AXIS_BITS-1:0];
        return r;
    endfunction

    logic [DIM_W-1:0]         edx, edy, edz;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic [AXIS_BITS-1:0]     vox_x_reg, vox_y_reg, vox_z_reg;
    logic [DXY_W-1:0]         dxy_reg;
    logic [AXIS_BITS-1:0]     px_reg;
    logic [T1_W-1:0]          t1_reg;
    logic [T2_W-1:0]          t2_reg;
    logic [SUM_W-1:0]         sum;
    logic [ADDR_W-1:0]        addr_reg;
    logic [STAGES-1:0]        valid_reg;

    assign edx = eff_dim(cfg.dim_x);
    assign edy = eff_dim(cfg.dim_y);
    assign edz = eff_dim(cfg.dim_z);

    // stage 1: coordinate times reciprocal voxel size
    always_ff @(posedge clk)
    begin
        prod_x_reg <= PROD_W'(coord_x) * PROD_W'($signed({1'b0, cfg.inv_x}));
        prod_y_reg <= PROD_W'(coord_y) * PROD_W'($signed({1'b0, cfg.inv_y}));
        prod_z_reg <= PROD_W'(coord_z) * PROD_W'($signed({1'b0, cfg.inv_z}));
    end

    // stage 2: floor and clamp each axis on its own, plane size
    always_ff @(posedge clk)
    begin
        vox_x_reg <= clamp_axis(prod_x_reg, edx);
        vox_y_reg <= clamp_axis(prod_y_reg, edy);
        vox_z_reg <= clamp_axis(prod_z_reg, edz);
        dxy_reg   <= DXY_W'(edx) * DXY_W'(edy);
    end

    // stage 3: row and plane offsets
    always_ff @(posedge clk)
    begin
        px_reg <= vox_x_reg;
        t1_reg <= T1_W'(vox_y_reg) * T1_W'(edx);
        t2_reg <= T2_W'(vox_z_reg) * T2_W'(dxy_reg);
    end

    // stage 4: linear index, wrapped to the store size
    assign sum = SUM_W'(px_reg) + SUM_W'(t1_reg) + SUM_W'(t2_reg);

    always_ff @(posedge clk)
    begin
        addr_reg <= sum[ADDR_W-1:0];
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], start};
        end
    end

    assign map_valid = valid_reg[STAGES-1];
    assign map_addr  = addr_reg;

endmodule

`default_nettype wire

@@ rtl/streamline_roi_mask_filter_top.sv @@
// ----------------------------------------------------------------------------
// streamline_roi_mask_filter_top
// Streamline filter against a one-bit region-of-interest mask volume.
// ----------------------------------------------------------------------------
// Usage
//   stream: valid/ready channel. action 0 writes mask_nonzero at the low
//   3*AXIS_BITS bits of mask_address; action 1 presents one track point.
//   result: valid/ready channel, one transaction per track, at the point
//   that carries last_point: keep_track and the saturating kept_total.
//   cfg_we/cfg_index/cfg_data write the scale and dimension registers;
//   write them only while no point is in flight.
// Timing
//   Mask writes are taken in idle and can follow each other every cycle
//   while no point is in flight. A point's accepting edge loads the first
//   of 4 voxel index stages; the mask is read after the last stage, and
//   the hit is folded after that. A result becomes valid with the fold of
//   its last point once the result register is free. The control keeps one
//   point in flight and holds ready low until its hit is folded.
// Reset
//   Registers return to unit scale and 128 voxels per axis, hit flag and
//   kept count clear. The mask volume is not cleared; load it before use.
// Stalls
//   A waiting result does not block the next points; a second final point
//   holds in the lookup state until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module streamline_roi_mask_filter_top #(
    parameter int AXIS_BITS = rmf_pkg::AXIS_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmf_pkg::CFG_DATA_W-1:0]     cfg_data,
    rmf_stream_if.sink                              stream,
    rmf_result_if.source                            result
);

    localparam int ADDR_W = 3 * AXIS_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_LOOK
    } state_t;

    rmf_pkg::cfg_t                  cfg_reg;
    state_t                         state_reg, state_next;
    logic                           hit_reg, hit_next;
    logic                           last_reg, last_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           keep_reg, keep_next;
    logic [rmf_pkg::COUNT_W-1:0]    kept_reg, kept_next;

    logic                           accept;
    logic                           ram_we;
    logic                           ram_re;
    logic                           ram_rdata;
    logic                           map_start;
    logic                           map_valid;
    logic [ADDR_W-1:0]              map_addr;
    logic                           hit_now;
    logic                           res_free;
    logic                           load_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_x <= rmf_pkg::INV_RESET;
            cfg_reg.inv_y <= rmf_pkg::INV_RESET;
            cfg_reg.inv_z <= rmf_pkg::INV_RESET;
            cfg_reg.dim_x <= rmf_pkg::DIM_RESET;
            cfg_reg.dim_y <= rmf_pkg::DIM_RESET;
            cfg_reg.dim_z <= rmf_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rmf_pkg::REG_INV_X: cfg_reg.inv_x <= cfg_data[rmf_pkg::INV_W-1:0];
                rmf_pkg::REG_INV_Y: cfg_reg.inv_y <= cfg_data[rmf_pkg::INV_W-1:0];
                rmf_pkg::REG_INV_Z: cfg_reg.inv_z <= cfg_data[rmf_pkg::INV_W-1:0];
                rmf_pkg::REG_DIM_X: cfg_reg.dim_x <= cfg_data[rmf_pkg::DIMCFG_W-1:0];
                rmf_pkg::REG_DIM_Y: cfg_reg.dim_y <= cfg_data[rmf_pkg::DIMCFG_W-1:0];
                rmf_pkg::REG_DIM_Z: cfg_reg.dim_z <= cfg_data[rmf_pkg::DIMCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction decode
    assign stream.ready = (state_reg == S_IDLE);
    assign accept       = stream.valid && stream.ready;
    assign ram_we       = accept && (stream.action == rmf_pkg::ACT_MASK_WRITE);
    assign map_start    = accept && (stream.action == rmf_pkg::ACT_POINT);

    // mask read once the index is ready; writes only happen in idle, so the
    // read never meets a write to the same entry
    assign ram_re = (state_reg == S_MAP) && map_valid;

    rmf_voxel_map #(
        .AXIS_BITS (AXIS_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (map_start),
        .coord_x   (stream.coord_x),
        .coord_y   (stream.coord_y),
        .coord_z   (stream.coord_z),
        .cfg       (cfg_reg),
        .map_valid (map_valid),
        .map_addr  (map_addr)
    );

    rmf_mask_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(stream.mask_address)),
        .wdata (stream.mask_nonzero),
        .re    (ram_re),
        .raddr (map_addr),
        .rdata (ram_rdata)
    );

    // hit fold and result hand-off
    assign hit_now  = hit_reg | ram_rdata;
    assign res_free = !out_valid_reg || result.ready;
    assign load_res = (state_reg == S_LOOK) && last_reg && res_free;

    always_comb
    begin
        state_next     = state_reg;
        hit_next       = hit_reg;
        last_next      = last_reg;
        keep_next      = keep_reg;
        kept_next      = kept_reg;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (map_start)
                begin
                    last_next  = stream.last_point;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                if (map_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (!last_reg)
                begin
                    hit_next   = hit_now;
                    state_next = S_IDLE;
                end
                else if (res_free)
                begin
                    out_valid_next = 1'b1;
                    keep_next      = hit_now;
                    if (hit_now && (kept_reg != '1))
                    begin
                        kept_next = kept_reg + rmf_pkg::COUNT_W'(1);
                    end
                    hit_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
            kept_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            keep_reg      <= keep_next;
            kept_reg      <= kept_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.keep_track = keep_reg;
    assign result.kept_total = kept_reg;

    // mask port never reads and writes in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("mask read and write in the same cycle");

    // index pipeline finishes only while a point waits for it
    a_map_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        map_valid |-> (state_reg == S_MAP))
        else $error("voxel index finished outside the map state");

    // kept count never goes down
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (kept_reg >= $past(kept_reg)))
        else $error("kept count decreased");

    // a finished track leaves the hit flag clear
    a_hit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |=> !hit_reg)
        else $error("hit flag survived the end of a track");

endmodule

`default_nettype wire
